FILE: rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
package gsa_pkg;

    localparam int MODE_W = 3;
    localparam int IDX_W  = 8;
    localparam int VER_W  = 8;
    localparam int CT_W   = 5;
    localparam int QM_W   = 32;

    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TEST   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DEAD   = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIFO_RD,
        ST_SLOT_RD,
        ST_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic fifo_rd;
        logic slot_rd;
        logic exec;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pop_fifo;
        logic out_stall;
    } t_sts;

endpackage

FILE: rtl/gsa_ctrl.sv
// Sequencing state machine for the slot allocator.
module gsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gsa_pkg::t_sts  i_sts,
    output gsa_pkg::t_cmd  o_cmd,
    output logic           o_ready
);
    import gsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.pop_fifo ? ST_FIFO_RD : ST_SLOT_RD;
                end
            end
            ST_FIFO_RD: n_state = ST_SLOT_RD;
            ST_SLOT_RD: n_state = ST_EXEC;
            ST_EXEC: begin
                if (!i_sts.out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            ST_FIFO_RD: o_cmd.fifo_rd = 1'b1;
            ST_SLOT_RD: o_cmd.slot_rd = 1'b1;
            ST_EXEC:    o_cmd.exec    = !i_sts.out_stall;
            default: begin
                o_cmd   = '0;
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/gsa_dpath.sv
// Slot tables, free-slot FIFO, counters and result register.
module gsa_dpath #(
    parameter int MAX_SLOTS    = 256,
    parameter int MASK_BITS    = 32,
    parameter int VERSION_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gsa_pkg::t_cmd                i_cmd,
    output gsa_pkg::t_sts                o_sts,
    input  logic [gsa_pkg::MODE_W-1:0]   i_mode,
    input  logic [gsa_pkg::IDX_W-1:0]    i_handle_index,
    input  logic [gsa_pkg::VER_W-1:0]    i_handle_version,
    input  logic [gsa_pkg::CT_W-1:0]     i_component_type,
    input  logic [gsa_pkg::QM_W-1:0]     i_query_mask,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [gsa_pkg::IDX_W-1:0]    o_out_index,
    output logic [gsa_pkg::VER_W-1:0]    o_out_version,
    output logic                         o_flag,
    output logic [gsa_pkg::QM_W-1:0]     o_mask_out,
    output logic                         o_status
);
    import gsa_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = SW + 1;
    localparam int VB = VERSION_BITS;
    localparam int MB = MASK_BITS;
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_SLOTS);
    localparam logic [SW-1:0] LAST_S  = SW'(MAX_SLOTS - 1);
    localparam logic [31:0]   MAX_U   = 32'(MAX_SLOTS);
    localparam logic [6:0]    MB_C    = 7'(MASK_BITS);

    // storage
    logic [VB-1:0] mem_ver  [MAX_SLOTS];
    logic [MB-1:0] mem_mask [MAX_SLOTS];
    logic [SW-1:0] mem_fifo [MAX_SLOTS];

    // captured beat
    logic [MODE_W-1:0] r_mode;
    logic [IDX_W-1:0]  r_index;
    logic [VER_W-1:0]  r_version;
    logic [CT_W-1:0]   r_ctype;
    logic [QM_W-1:0]   r_qmask;
    logic              r_pop;

    // read stage
    logic [SW-1:0] r_fifo_q;
    logic [SW-1:0] r_slot;
    logic [VB-1:0] r_ent_ver;
    logic [MB-1:0] r_ent_mask;
    logic          r_used;
    logic          r_in_range;

    // control state
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_next;

    // result register
    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_index;
    logic [VER_W-1:0]  r_o_version;
    logic              r_o_flag;
    logic [QM_W-1:0]   r_o_mask;
    logic              r_o_status;

    logic [SW-1:0] idx_addr;
    logic [SW-1:0] slot_addr;
    logic          in_range;
    logic          addr_used;
    logic [VB-1:0] ent_ver;
    logic [MB-1:0] ent_mask;
    logic          live;
    logic          ct_ok;
    logic [MB-1:0] bit_sel;
    logic [MB-1:0] qm;
    logic [SW-1:0] head_adv;
    logic [SW-1:0] tail_adv;

    // exec results
    logic          wr_en;
    logic [VB-1:0] wr_ver;
    logic [MB-1:0] wr_mask;
    logic          push;
    logic          pop;
    logic          take_new;
    logic [IDX_W-1:0] res_index;
    logic [VER_W-1:0] res_version;
    logic             res_flag;
    logic [QM_W-1:0]  res_mask;
    logic             res_status;

    assign o_sts.pop_fifo  = (i_mode == MODE_CREATE) && (r_count != '0);
    assign o_sts.out_stall = r_o_valid && !i_ready;

    assign idx_addr  = SW'(r_index);
    assign in_range  = {{(32-IDX_W){1'b0}}, r_index} < MAX_U;
    assign slot_addr = r_pop ? r_fifo_q
                     : (r_mode == MODE_CREATE) ? r_next[SW-1:0] : idx_addr;
    // slots at or above the fill mark were never created: version and mask read as zero
    assign addr_used = (CW'(slot_addr) < r_next)
                       && (r_pop || (r_mode == MODE_CREATE) || in_range);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_index   <= i_handle_index;
            r_version <= i_handle_version;
            r_ctype   <= i_component_type;
            r_qmask   <= i_query_mask;
            r_pop     <= o_sts.pop_fifo;
        end
        if (i_cmd.fifo_rd) begin
            r_fifo_q <= mem_fifo[r_head];
        end
        if (i_cmd.slot_rd) begin
            r_slot     <= slot_addr;
            r_ent_ver  <= mem_ver[slot_addr];
            r_ent_mask <= mem_mask[slot_addr];
            r_used     <= addr_used;
            r_in_range <= in_range;
        end
        if (i_cmd.exec && wr_en) begin
            mem_ver[r_slot]  <= wr_ver;
            mem_mask[r_slot] <= wr_mask;
        end
        if (i_cmd.exec && push) begin
            mem_fifo[r_tail] <= idx_addr;
        end
    end

    assign ent_ver  = r_used ? r_ent_ver : '0;
    assign ent_mask = r_used ? r_ent_mask : '0;
    assign live     = r_used && (ent_ver == VB'(r_version));
    assign ct_ok    = 7'(r_ctype) < MB_C;
    assign bit_sel  = MB'(1) << r_ctype;
    assign qm       = MB'(r_qmask);
    assign head_adv = (r_head == LAST_S) ? '0 : r_head + SW'(1);
    assign tail_adv = (r_tail == LAST_S) ? '0 : r_tail + SW'(1);

    always_comb begin
        wr_en       = 1'b0;
        wr_ver      = ent_ver;
        wr_mask     = ent_mask;
        push        = 1'b0;
        pop         = 1'b0;
        take_new    = 1'b0;
        res_index   = '0;
        res_version = '0;
        res_flag    = 1'b0;
        res_mask    = '0;
        res_status  = 1'b0;
        case (r_mode)
            MODE_CREATE: begin
                if (r_pop || (r_next < MAX_C)) begin
                    pop         = r_pop;
                    take_new    = !r_pop;
                    wr_en       = 1'b1;
                    wr_mask     = '0;
                    res_index   = IDX_W'(r_slot);
                    res_version = VER_W'(ent_ver);
                end else begin
                    res_status = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (live) begin
                    wr_en  = 1'b1;
                    wr_ver = ent_ver + VB'(1);
                    push   = (r_count < MAX_C);
                end
            end
            MODE_ADD: begin
                if (live && ct_ok) begin
                    wr_en   = 1'b1;
                    wr_mask = ent_mask | bit_sel;
                end
            end
            MODE_CLEAR: begin
                if (r_used && ct_ok) begin
                    wr_en   = 1'b1;
                    wr_mask = ent_mask & ~bit_sel;
                end
            end
            MODE_TEST: res_flag = ((qm & ent_mask) == qm);
            MODE_READ: res_mask = QM_W'(ent_mask);
            MODE_DEAD: res_flag = r_in_range ? (ent_ver != VB'(r_version)) : 1'b1;
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_next    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (pop) begin
                    r_head  <= head_adv;
                    r_count <= r_count - CW'(1);
                end
                if (push) begin
                    r_tail  <= tail_adv;
                    r_count <= r_count + CW'(1);
                end
                if (take_new) begin
                    r_next <= r_next + CW'(1);
                end
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_index   <= res_index;
            r_o_version <= res_version;
            r_o_flag    <= res_flag;
            r_o_mask    <= res_mask;
            r_o_status  <= res_status;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_index   = r_o_index;
    assign o_out_version = r_o_version;
    assign o_flag        = r_o_flag;
    assign o_mask_out    = r_o_mask;
    assign o_status      = r_o_status;

endmodule

FILE: rtl/generational_slot_allocator.sv
// Sequence: accept, then a FIFO read when create reuses a freed slot, then slot table read,
// then write-back with the result registered; one beat at a time, accepted only when idle;
// a held result delays write-back.
// Reset: synchronous active-low; clears FIFO pointers, count, fill mark and output valid.
// No clearing pass: slots at or above the fill mark read as version 0, mask 0.
module generational_slot_allocator #(
    parameter int MAX_SLOTS    = 256,
    parameter int MASK_BITS    = 32,
    parameter int VERSION_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gsa_pkg::MODE_W-1:0]   i_mode,
    input  logic [gsa_pkg::IDX_W-1:0]    i_handle_index,
    input  logic [gsa_pkg::VER_W-1:0]    i_handle_version,
    input  logic [gsa_pkg::CT_W-1:0]     i_component_type,
    input  logic [gsa_pkg::QM_W-1:0]     i_query_mask,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [gsa_pkg::IDX_W-1:0]    o_out_index,
    output logic [gsa_pkg::VER_W-1:0]    o_out_version,
    output logic                         o_flag,
    output logic [gsa_pkg::QM_W-1:0]     o_mask_out,
    output logic                         o_status
);
    import gsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    gsa_dpath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .MASK_BITS    (MASK_BITS),
        .VERSION_BITS (VERSION_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_mode),
        .i_handle_index   (i_handle_index),
        .i_handle_version (i_handle_version),
        .i_component_type (i_component_type),
        .i_query_mask     (i_query_mask),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_out_index      (o_out_index),
        .o_out_version    (o_out_version),
        .o_flag           (o_flag),
        .o_mask_out       (o_mask_out),
        .o_status         (o_status)
    );

    // one beat in flight: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a beat while one was in flight");

    // a failed create carries no handle and no query result
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_out_index == '0 && o_out_version == '0
                                   && !o_flag && o_mask_out == '0))
        else $error("failed create with non-zero fields");

    // the result register loads only when the block is not idle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid) && $past(i_rst_n)) |-> $past(!o_ready))
        else $error("result appeared without an item in flight");

endmodule
